// ===== rtl/bitp_pkg.sv =====
// bitp_pkg: shared types and constants for the page byte converter
// used by bitp_front, bitp_cmdq, bitp_back and binary_image_to_page_bytes
// no dependencies
package bitp_pkg;

    localparam int DEF_IMAGE_WIDTH  = 80;
    localparam int DEF_IMAGE_HEIGHT = 60;
    localparam int CMDQ_DEPTH       = 4;

    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_LINE  = 2'd1;
    localparam logic [1:0] MODE_SYNC  = 2'd2;

    typedef enum logic {
        CMD_STORE,
        CMD_EMIT
    } cmd_kind_t;

    // sel is the band row for a store, the page for an emit
    typedef struct packed {
        cmd_kind_t  kind;
        logic [2:0] sel;
        logic [7:0] pix;
    } cmd_head_t;

endpackage

// ===== rtl/bitp_front.sv =====
// bitp_front: stream parser, tracks frame, line and byte position
// issues store or emit commands into the command queue
// depends on bitp_pkg
module bitp_front #(
    parameter int IMAGE_WIDTH  = bitp_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = bitp_pkg::DEF_IMAGE_HEIGHT,
    localparam int BPR = IMAGE_WIDTH / 8,
    localparam int XW  = (BPR > 1) ? $clog2(BPR) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [1:0]          mode,
    input  logic [7:0]          pixel_byte,
    input  logic                cmd_full,
    output logic                full,
    output logic                cmd_push,
    output bitp_pkg::cmd_head_t cmd_head,
    output logic [XW-1:0]       cmd_x
);

    localparam int FULL_ROWS = (IMAGE_HEIGHT / 8) * 8;
    localparam int ROW_CAP   = FULL_ROWS + 1;
    localparam int BYTE_CAP  = BPR + 1;
    localparam int RCW       = $clog2(ROW_CAP + 1);
    localparam int BCW       = $clog2(BYTE_CAP + 1);

    logic [RCW-1:0] row_count_reg, row_count_next;
    logic [BCW-1:0] byte_count_reg, byte_count_next;
    logic           show_frame_reg, show_frame_next;
    logic           line_open_reg, line_open_next;

    logic           accept;
    logic           cmd_valid;
    logic [RCW-1:0] row;
    logic [RCW+5:0] row_ext;
    logic [BCW-1:0] bx;

    assign accept   = push && !cmd_full;
    assign full     = cmd_full;
    assign cmd_push = accept && cmd_valid;
    assign row      = row_count_reg - RCW'(1);
    assign row_ext  = {6'b0, row};
    assign bx       = byte_count_reg - BCW'(1);

    always_comb
    begin
        row_count_next  = row_count_reg;
        byte_count_next = byte_count_reg;
        show_frame_next = show_frame_reg;
        line_open_next  = line_open_reg;
        cmd_valid       = 1'b0;
        cmd_head        = '0;
        cmd_x           = bx[XW-1:0];
        case (mode)
            bitp_pkg::MODE_SYNC:
            begin
                show_frame_next = !show_frame_reg;
                line_open_next  = 1'b0;
                row_count_next  = '0;
                byte_count_next = '0;
            end
            bitp_pkg::MODE_LINE:
            begin
                if (row_count_reg < RCW'(ROW_CAP))
                begin
                    row_count_next = row_count_reg + RCW'(1);
                end
                byte_count_next = '0;
                line_open_next  = 1'b1;
            end
            bitp_pkg::MODE_PIXEL:
            begin
                if (line_open_reg && row_count_reg != '0)
                begin
                    if (byte_count_reg < BCW'(BYTE_CAP))
                    begin
                        byte_count_next = byte_count_reg + BCW'(1);
                    end
                    // skip dummy byte, extra bytes and rows past last page
                    if (byte_count_reg != '0 && byte_count_reg <= BCW'(BPR)
                        && row < RCW'(FULL_ROWS))
                    begin
                        cmd_head.pix = pixel_byte;
                        if (row[2:0] != 3'd7)
                        begin
                            cmd_valid     = 1'b1;
                            cmd_head.kind = bitp_pkg::CMD_STORE;
                            cmd_head.sel  = row[2:0];
                        end
                        else if (show_frame_reg)
                        begin
                            cmd_valid     = 1'b1;
                            cmd_head.kind = bitp_pkg::CMD_EMIT;
                            cmd_head.sel  = row_ext[5:3];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= '0;
            byte_count_reg <= '0;
            show_frame_reg <= 1'b1;
            line_open_reg  <= 1'b0;
        end
        else if (accept)
        begin
            row_count_reg  <= row_count_next;
            byte_count_reg <= byte_count_next;
            show_frame_reg <= show_frame_next;
            line_open_reg  <= line_open_next;
        end
    end

endmodule

// ===== rtl/bitp_cmdq.sv =====
// bitp_cmdq: small command queue between parser and band store
// depends on bitp_pkg
module bitp_cmdq #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = bitp_pkg::CMDQ_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              do_push, do_pop;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/bitp_back.sv =====
// bitp_back: band store memory and page byte sequencer
// runs store and emit commands, emits eight page bytes per emit
// depends on bitp_pkg
module bitp_back #(
    parameter int IMAGE_WIDTH = bitp_pkg::DEF_IMAGE_WIDTH,
    localparam int BPR = IMAGE_WIDTH / 8,
    localparam int XW  = (BPR > 1) ? $clog2(BPR) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_empty,
    input  bitp_pkg::cmd_head_t cmd_head,
    input  logic [XW-1:0]       cmd_x,
    output logic                cmd_pop,
    output logic                empty,
    input  logic                pop,
    output logic [2:0]          page,
    output logic [6:0]          column,
    output logic [7:0]          page_byte,
    output logic                last_of_run
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t         state_reg;
    logic [2:0]     k_reg;
    logic [2:0]     page_reg;
    logic [XW-1:0]  x_reg;
    logic [7:0]     pix_reg;

    logic [55:0]    mem [BPR];
    logic [BPR-1:0] valid_reg;
    logic [55:0]    rd_data_reg;
    logic           rd_valid_reg;

    logic           last_pop, take, take_emit, take_store;
    logic [2:0]     bitpos;
    logic [XW+9:0]  col_ext;
    logic [5:0]     lane_sh;

    assign last_pop   = (state_reg == ST_EMIT) && pop && (k_reg == 3'd7);
    assign take       = !cmd_empty && ((state_reg == ST_IDLE) || last_pop);
    assign take_emit  = take && (cmd_head.kind == bitp_pkg::CMD_EMIT);
    assign take_store = take && (cmd_head.kind == bitp_pkg::CMD_STORE);
    assign cmd_pop    = take;
    assign lane_sh    = {cmd_head.sel, 3'b000};

    // band store, byte lane writes, first write to an entry clears the rest
    always_ff @(posedge clk)
    begin
        if (take_store)
        begin
            if (valid_reg[cmd_x])
            begin
                mem[cmd_x][lane_sh +: 8] <= cmd_head.pix;
            end
            else
            begin
                mem[cmd_x] <= {48'b0, cmd_head.pix} << lane_sh;
            end
        end
        if (take_emit)
        begin
            rd_data_reg  <= mem[cmd_x];
            rd_valid_reg <= valid_reg[cmd_x];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (take_store)
        begin
            valid_reg[cmd_x] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            page_reg  <= '0;
            x_reg     <= '0;
            pix_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (take_emit)
                    begin
                        state_reg <= ST_EMIT;
                        k_reg     <= '0;
                        page_reg  <= cmd_head.sel;
                        x_reg     <= cmd_x;
                        pix_reg   <= cmd_head.pix;
                    end
                end
                ST_EMIT:
                begin
                    if (pop)
                    begin
                        // wraps to zero after the eighth word
                        k_reg <= k_reg + 3'd1;
                        if (k_reg == 3'd7)
                        begin
                            if (take_emit)
                            begin
                                page_reg <= cmd_head.sel;
                                x_reg    <= cmd_x;
                                pix_reg  <= cmd_head.pix;
                            end
                            else
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign empty       = state_reg != ST_EMIT;
    assign bitpos      = 3'd7 - k_reg;
    assign col_ext     = {7'b0, x_reg, k_reg};
    assign column      = col_ext[6:0];
    assign page        = page_reg;
    assign last_of_run = k_reg == 3'd7;

    always_comb
    begin
        logic [7:0] row_byte;
        page_byte = '0;
        for (int j = 0; j < 7; j++)
        begin
            row_byte     = rd_data_reg[8*j +: 8];
            page_byte[j] = row_byte[bitpos] & rd_valid_reg;
        end
        page_byte[7] = pix_reg[bitpos];
    end

endmodule

// ===== rtl/binary_image_to_page_bytes.sv =====
// binary_image_to_page_bytes: camera rows to display page bytes, top level
// built from bitp_front, bitp_cmdq and bitp_back, uses bitp_pkg
//
// input queue side: push with mode and pixel_byte, held off by full
//   mode selects pixel word, line start or frame sync
// result queue side: page, column, page_byte and last_of_run are valid
//   while empty is low, and the word is taken when pop is high
// the parser takes one word per cycle while full is low, and hands store or
//   emit commands to a four deep command queue, so input keeps flowing
//   while results wait; a stored row byte is written in the cycle it is taken
// on the eighth row of a band in a shown frame each pixel word gives eight
//   page words, one per cycle while pop is high; the band store read happens
//   on the cycle the command is taken, so the first word shows in the next
//   cycle; the next emit is taken with the last pop, leaving no gap
// an emit reaches its first result through the queue slot and read register
// if pop stays low, the sequencer holds its word, the command queue fills
//   and full rises; nothing is dropped
// reset clears the band store through per entry valid bits, clears the
//   counters and starts with a shown frame; no clearing pass is needed
module binary_image_to_page_bytes #(
    parameter int IMAGE_WIDTH  = bitp_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = bitp_pkg::DEF_IMAGE_HEIGHT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] mode,
    input  logic [7:0] pixel_byte,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] page,
    output logic [6:0] column,
    output logic [7:0] page_byte,
    output logic       last_of_run
);

    localparam int BPR    = IMAGE_WIDTH / 8;
    localparam int XW     = (BPR > 1) ? $clog2(BPR) : 1;
    localparam int HEAD_W = $bits(bitp_pkg::cmd_head_t);
    localparam int CMD_W  = HEAD_W + XW;

    logic                cmd_full, cmd_push, cmd_empty, cmd_pop;
    bitp_pkg::cmd_head_t in_head, out_head;
    logic [XW-1:0]       in_x, out_x;
    logic [CMD_W-1:0]    q_wdata, q_rdata;

    assign q_wdata  = {in_head, in_x};
    assign out_head = bitp_pkg::cmd_head_t'(q_rdata[CMD_W-1:XW]);
    assign out_x    = q_rdata[XW-1:0];

    bitp_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .mode       (mode),
        .pixel_byte (pixel_byte),
        .cmd_full   (cmd_full),
        .full       (full),
        .cmd_push   (cmd_push),
        .cmd_head   (in_head),
        .cmd_x      (in_x)
    );

    bitp_cmdq #(
        .DATA_W (CMD_W),
        .DEPTH  (bitp_pkg::CMDQ_DEPTH)
    ) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (q_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (q_rdata),
        .empty (cmd_empty)
    );

    bitp_back #(
        .IMAGE_WIDTH (IMAGE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_empty   (cmd_empty),
        .cmd_head    (out_head),
        .cmd_x       (out_x),
        .cmd_pop     (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .page        (page),
        .column      (column),
        .page_byte   (page_byte),
        .last_of_run (last_of_run)
    );

    // the command queue is never written while full
    a_no_cmd_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command pushed into full queue");

    // the eighth word of a run sits on the last column of its group
    a_last_column: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_of_run) |-> (column[2:0] == 3'b111))
        else $error("last_of_run on wrong column");

    // inside a run the next word follows on the next column of the same page
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_of_run) |=>
            (!empty && column == $past(column) + 7'd1 && page == $past(page)))
        else $error("run broken");

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for binary_image_to_page_bytes
// holds its own band store model and checks every page word in order
// depends on bitp_pkg and the binary_image_to_page_bytes rtl
`timescale 1ns / 100ps

module tb;

    localparam int IMG_W         = bitp_pkg::DEF_IMAGE_WIDTH;
    localparam int IMG_H         = bitp_pkg::DEF_IMAGE_HEIGHT;
    localparam int ROW_BYTES     = IMG_W / 8;
    localparam int PAGED_ROWS    = (IMG_H / 8) * 8;
    localparam int LINE_LIMIT    = PAGED_ROWS + 1;
    localparam int BYTE_LIMIT    = ROW_BYTES + 1;
    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef struct packed {
        logic [2:0] page;
        logic [6:0] column;
        logic [7:0] page_byte;
        logic       last_of_run;
    } page_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] mode = bitp_pkg::MODE_PIXEL;
    logic [7:0] pixel_byte = 8'd0;
    logic       empty;
    logic       pop = 1'b0;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] page_byte;
    logic       last_of_run;

    page_word_t  pending_page_words[$];
    page_word_t  want;
    logic [55:0] band_rows [ROW_BYTES];
    int unsigned lines_seen = 0;
    int unsigned bytes_seen = 0;
    bit          frame_shown = 1'b1;
    bit          line_active = 1'b0;
    int          push_gap_pct = 0;
    int          pop_gap_pct = 0;
    int          words_sent = 0;
    int          error_count = 0;

    binary_image_to_page_bytes #(
        .IMAGE_WIDTH  (IMG_W),
        .IMAGE_HEIGHT (IMG_H)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .pixel_byte  (pixel_byte),
        .empty       (empty),
        .pop         (pop),
        .page        (page),
        .column      (column),
        .page_byte   (page_byte),
        .last_of_run (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        foreach (band_rows[i])
            band_rows[i] = '0;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // band store model: stores seven rows, the eighth row emits page words in a shown frame
    function automatic void predict_page_words(input logic [1:0] m, input logic [7:0] p);
        int unsigned x;
        int unsigned row;
        logic [55:0] held;
        page_word_t  w;
        if (m == bitp_pkg::MODE_SYNC)
        begin
            frame_shown = !frame_shown;
            line_active = 1'b0;
            lines_seen  = 0;
            bytes_seen  = 0;
            return;
        end
        if (m == bitp_pkg::MODE_LINE)
        begin
            if (lines_seen < LINE_LIMIT)
                lines_seen++;
            bytes_seen  = 0;
            line_active = 1'b1;
            return;
        end
        if (m != bitp_pkg::MODE_PIXEL || !line_active || lines_seen == 0)
            return;
        x = bytes_seen;
        if (bytes_seen < BYTE_LIMIT)
            bytes_seen++;
        if (x == 0 || x > ROW_BYTES)
            return;
        x   = x - 1;
        row = lines_seen - 1;
        if (row >= PAGED_ROWS)
            return;
        if (row % 8 < 7)
        begin
            band_rows[x][(row % 8) * 8 +: 8] = p;
            return;
        end
        if (!frame_shown)
            return;
        held = band_rows[x];
        for (int k = 0; k < 8; k++)
        begin
            for (int j = 0; j < 7; j++)
                w.page_byte[j] = held[j * 8 + 7 - k];
            w.page_byte[7]  = p[7 - k];
            w.page          = 3'(row / 8);
            w.column        = 7'(x * 8 + k);
            w.last_of_run   = (k == 7);
            pending_page_words.push_back(w);
        end
    endfunction

    task automatic send_word(input logic [1:0] m, input logic [7:0] p);
        if ($urandom_range(99) < push_gap_pct)
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < push_gap_pct);
        end
        push       <= 1'b1;
        mode       <= m;
        pixel_byte <= p;
        do
            @(posedge clk);
        while (full);
        predict_page_words(m, p);
        if (m != MODE_NONE)
            words_sent++;
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending_page_words.size() != 0);
    endtask

    // result side: random pop, every word checked against the oldest pending one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_page_words.size() == 0)
                    report_error($sformatf("unexpected word page %0d column %0d", page, column));
                else
                begin
                    want = pending_page_words.pop_front();
                    if (page !== want.page)
                        report_error($sformatf("page %0d, want %0d", page, want.page));
                    if (column !== want.column)
                        report_error($sformatf("column %0d, want %0d", column, want.column));
                    if (page_byte !== want.page_byte)
                        report_error($sformatf("page_byte %h, want %h (column %0d)",
                                               page_byte, want.page_byte, want.column));
                    if (last_of_run !== want.last_of_run)
                        report_error($sformatf("last_of_run %b, want %b (column %0d)",
                                               last_of_run, want.last_of_run, want.column));
                end
            end
            pop <= ($urandom_range(99) >= pop_gap_pct);
        end
    end

    // one band by hand: stray words, short rows, extreme pixels, eighth row
    task automatic test_edge_rows();
        send_word(bitp_pkg::MODE_PIXEL, 8'hA5);
        send_word(MODE_NONE, 8'hFF);
        send_word(bitp_pkg::MODE_LINE, 8'h00);
        send_word(bitp_pkg::MODE_PIXEL, 8'h00);
        send_word(bitp_pkg::MODE_PIXEL, 8'hFF);
        send_word(bitp_pkg::MODE_LINE, 8'h00);
        send_word(bitp_pkg::MODE_PIXEL, 8'hFF);
        send_word(bitp_pkg::MODE_PIXEL, 8'h00);
        send_word(bitp_pkg::MODE_LINE, 8'h00);
        send_word(bitp_pkg::MODE_PIXEL, 8'h00);
        send_word(bitp_pkg::MODE_PIXEL, 8'hAA);
        send_word(bitp_pkg::MODE_LINE, 8'h00);
        send_word(bitp_pkg::MODE_LINE, 8'h00);
        send_word(bitp_pkg::MODE_LINE, 8'h00);
        send_word(bitp_pkg::MODE_LINE, 8'h00);
        send_word(bitp_pkg::MODE_PIXEL, 8'h00);
        send_word(bitp_pkg::MODE_PIXEL, 8'h55);
        send_word(bitp_pkg::MODE_LINE, 8'h00);
        send_word(bitp_pkg::MODE_PIXEL, 8'h3C);
        send_word(bitp_pkg::MODE_PIXEL, 8'h81);
        send_word(bitp_pkg::MODE_PIXEL, 8'h7E);
        send_word(bitp_pkg::MODE_SYNC, 8'h00);
    endtask

    task automatic send_frame();
        int lines;
        int nb;
        send_word(bitp_pkg::MODE_SYNC, 8'($urandom));
        lines = ($urandom_range(3) == 0) ? $urandom_range(56, 62) : $urandom_range(8, 24);
        for (int r = 0; r < lines; r++)
        begin
            send_word(bitp_pkg::MODE_LINE, 8'($urandom));
            if (lines > 24 && r < 48 && r % 8 != 7)
                nb = $urandom_range(0, 1);
            else if ($urandom_range(5) == 0)
                nb = $urandom_range(10, 13);
            else if (r % 8 == 7)
                nb = $urandom_range(2, 6);
            else
                nb = $urandom_range(0, 4);
            repeat (nb)
                send_word(bitp_pkg::MODE_PIXEL, 8'($urandom));
        end
    endtask

    task automatic test_random_frames(input int budget, input bit with_pause);
        int  start;
        bit  paused;
        start  = words_sent;
        paused = 1'b0;
        while (words_sent - start < budget)
        begin
            if ($urandom_range(99) < 85)
                send_frame();
            else
                repeat ($urandom_range(1, 4))
                    send_word(2'($urandom_range(0, 3)), 8'($urandom));
            if (with_pause && !paused && words_sent - start >= budget / 2)
            begin
                hold_until_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        push_gap_pct = 37;
        pop_gap_pct  = 76;
        test_edge_rows();
        test_random_frames(60, 1'b1);
        push_gap_pct = 76;
        pop_gap_pct  = 37;
        test_random_frames(60, 1'b0);
        push_gap_pct = 0;
        pop_gap_pct  = 0;
        test_random_frames(60, 1'b0);
        hold_until_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("binary_image_to_page_bytes: match");
        else
            $display("binary_image_to_page_bytes: mismatch");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("binary_image_to_page_bytes: mismatch");
        $finish;
    end

endmodule
